// ===== rtl/slot_task_buffer_unit_macros.svh =====
// assertion macros for the slot task buffer unit checker
// no dependencies; included by the checker file
`ifndef SLOT_TASK_BUFFER_UNIT_MACROS_SVH
`define SLOT_TASK_BUFFER_UNIT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define STBU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define STBU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/stbu_pkg.sv =====
// shared types, codes and field layout for the slot task buffer unit
// no dependencies; used by the allocator, the top level and the checker
`default_nettype none

package stbu_pkg;

  // slot array geometry
  localparam int SLOTS      = 16;
  localparam int SLOT_IDX_W = $clog2(SLOTS);
  localparam int COUNT_W    = $clog2(SLOTS + 1);

  // field widths
  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int OUTCNT_W = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 64;
  localparam int THRESH_W = 8;

  // input tdata layout
  localparam int IN_DATA_W = 64;

  // output tdata layout, lowest bit up
  localparam int OUT_TAKEN_LSB  = 0;
  localparam int OUT_SLOT_LSB   = OUT_TAKEN_LSB + HANDLE_W;
  localparam int OUT_COUNT_LSB  = OUT_SLOT_LSB + 4;
  localparam int OUT_INS_LSB    = OUT_COUNT_LSB + 5;
  localparam int OUT_COMP_LSB   = OUT_INS_LSB + TOTAL_W;
  localparam int OUT_ENOUGH_BIT = OUT_COMP_LSB + TOTAL_W;
  localparam int OUT_USED_W     = OUT_ENOUGH_BIT + 1;
  localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 2'd0,
    MODE_TAKE    = 2'd1,
    MODE_OUTSIDE = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_ACCESS,
    ST_DONE
  } state_t;

  // slot update request from sequencer to allocator
  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [SLOT_IDX_W-1:0] idx;
  } alloc_ctrl_t;

  // allocator view of the slot array
  typedef struct packed {
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  used_found;
    logic [SLOT_IDX_W-1:0] used_idx;
    logic [COUNT_W-1:0]    count;
  } alloc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/stbu_slot_alloc.sv =====
// occupied bits, occupancy count and lowest free / lowest used slot search
// depends on stbu_pkg
`default_nettype none

module stbu_slot_alloc (
  input  wire                  clk,
  input  wire                  rst_n,
  input  stbu_pkg::alloc_ctrl_t ctrl,
  output stbu_pkg::alloc_stat_t stat
);

  logic [stbu_pkg::SLOTS-1:0]   occ_r;
  logic [stbu_pkg::SLOTS-1:0]   occ_nxt;
  logic [stbu_pkg::COUNT_W-1:0] count_r;
  logic [stbu_pkg::COUNT_W-1:0] count_nxt;

  logic [stbu_pkg::SLOTS-1:0]      free_vec;
  logic [stbu_pkg::SLOTS-1:0]      free_low;
  logic [stbu_pkg::SLOTS-1:0]      used_low;
  logic [stbu_pkg::SLOT_IDX_W-1:0] free_idx;
  logic [stbu_pkg::SLOT_IDX_W-1:0] used_idx;

  // slot bit and count updates
  always_comb begin
    occ_nxt   = occ_r;
    count_nxt = count_r;
    if (ctrl.set) begin
      occ_nxt[ctrl.idx] = 1'b1;
      count_nxt         = count_r + 1'b1;
    end else if (ctrl.clr) begin
      occ_nxt[ctrl.idx] = 1'b0;
      count_nxt         = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      count_r <= '0;
    end else begin
      occ_r   <= occ_nxt;
      count_r <= count_nxt;
    end
  end

  // isolate the lowest set bit of each vector with one add
  assign free_vec = ~occ_r;
  assign free_low = free_vec & (~free_vec + 1'b1);
  assign used_low = occ_r & (~occ_r + 1'b1);

  // one-hot to index, each bit contributes on its own
  always_comb begin
    free_idx = '0;
    used_idx = '0;
    for (int i = 0; i < stbu_pkg::SLOTS; i++) begin
      if (free_low[i]) free_idx = free_idx | stbu_pkg::SLOT_IDX_W'(i);
      if (used_low[i]) used_idx = used_idx | stbu_pkg::SLOT_IDX_W'(i);
    end
  end

  assign stat.free_found = |free_vec;
  assign stat.free_idx   = free_idx;
  assign stat.used_found = |occ_r;
  assign stat.used_idx   = used_idx;
  assign stat.count      = count_r;

endmodule

`default_nettype wire

// ===== rtl/slot_task_buffer_unit.sv =====
// slot task buffer unit: an accepted item passes through accept, slot search,
// slot and memory access with the shared 64-bit adder, and result load; only
// one item is in flight, and a new item is accepted once its result is loaded.
// the handle memory read is registered, which sets the access step.
// synchronous active-low reset clears state, result valid, occupied bits, count, totals, threshold;
// handle memory holds no reset and needs no clearing pass
`default_nettype none

module slot_task_buffer_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // config write, threshold in cfg_data[7:0]
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [stbu_pkg::THRESH_W-1:0]        cfg_data,
  // input item
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [stbu_pkg::IN_DATA_W-1:0]       in_tdata,  // task_handle, outside_count
  input  wire [stbu_pkg::MODE_W-1:0]          in_tuser,  // mode
  // result item
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // taken_handle, slot_used, occupied_count, inserted_total, completed_total,
  // enough_buffered, zero fill
  output logic [stbu_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [stbu_pkg::STATUS_W-1:0]       out_tuser  // status
);

  stbu_pkg::state_t state_r, state_nxt;

  // captured item
  stbu_pkg::mode_t                mode_r;
  logic [stbu_pkg::HANDLE_W-1:0]  handle_r;
  logic [stbu_pkg::OUTCNT_W-1:0]  outside_r;

  // search result
  logic                           hit_r, hit_nxt;
  logic [stbu_pkg::SLOT_IDX_W-1:0] idx_r, idx_nxt;

  // totals and threshold
  logic [stbu_pkg::TOTAL_W-1:0]   ins_r;
  logic [stbu_pkg::TOTAL_W-1:0]   comp_r;
  logic [stbu_pkg::THRESH_W-1:0]  thresh_r;

  // handle memory
  logic [stbu_pkg::HANDLE_W-1:0]  mem [stbu_pkg::SLOTS];
  logic [stbu_pkg::HANDLE_W-1:0]  mem_rd_r;

  // result register
  logic                            out_valid_r;
  logic [stbu_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [stbu_pkg::STATUS_W-1:0]   out_status_r;

  // sequencer outputs
  logic                  accept;
  logic                  do_access;
  logic                  out_load;
  stbu_pkg::alloc_ctrl_t ctrl;
  stbu_pkg::alloc_stat_t stat;

  // shared adder
  logic                          add_en;
  logic                          add_to_ins;
  logic [stbu_pkg::TOTAL_W-1:0]  add_a;
  logic [stbu_pkg::TOTAL_W-1:0]  add_b;
  logic [stbu_pkg::TOTAL_W-1:0]  add_sum;

  // result fields
  logic [stbu_pkg::STATUS_W-1:0] status;
  logic [stbu_pkg::HANDLE_W-1:0] taken;
  logic                          enough;

  stbu_slot_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // config port always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stbu_pkg::ST_IDLE:   if (in_tvalid) state_nxt = stbu_pkg::ST_FIND;
      stbu_pkg::ST_FIND:   state_nxt = stbu_pkg::ST_ACCESS;
      stbu_pkg::ST_ACCESS: state_nxt = stbu_pkg::ST_DONE;
      stbu_pkg::ST_DONE:   if (!out_valid_r || out_tready) state_nxt = stbu_pkg::ST_IDLE;
      default:             state_nxt = stbu_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    do_access = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      stbu_pkg::ST_IDLE:   in_tready = 1'b1;
      stbu_pkg::ST_FIND:   ;
      stbu_pkg::ST_ACCESS: do_access = 1'b1;
      stbu_pkg::ST_DONE:   out_load  = !out_valid_r || out_tready;
      default:             ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= stbu_pkg::mode_t'(in_tuser);
      handle_r  <= in_tdata[stbu_pkg::HANDLE_W-1:0];
      outside_r <= in_tdata[stbu_pkg::IN_DATA_W-1:stbu_pkg::HANDLE_W];
    end
  end

  // pick lowest free slot for add, lowest used slot for take
  always_comb begin
    hit_nxt = 1'b0;
    idx_nxt = '0;
    case (mode_r)
      stbu_pkg::MODE_ADD: begin
        hit_nxt = stat.free_found;
        idx_nxt = stat.free_idx;
      end
      stbu_pkg::MODE_TAKE: begin
        hit_nxt = stat.used_found;
        idx_nxt = stat.used_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == stbu_pkg::ST_FIND) begin
      hit_r <= hit_nxt;
      idx_r <= idx_nxt;
    end
  end

  // slot bit update
  assign ctrl.set = do_access && hit_r && (mode_r == stbu_pkg::MODE_ADD);
  assign ctrl.clr = do_access && hit_r && (mode_r == stbu_pkg::MODE_TAKE);
  assign ctrl.idx = idx_r;

  // handle memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.set) begin
      mem[idx_r] <= handle_r;
    end
    if (do_access) begin
      mem_rd_r <= mem[idx_r];
    end
  end

  // shared 64-bit adder for both totals
  assign add_to_ins = (mode_r == stbu_pkg::MODE_ADD);
  assign add_en     = do_access && (hit_r || (mode_r == stbu_pkg::MODE_OUTSIDE));
  assign add_a      = add_to_ins ? ins_r : comp_r;
  assign add_b      = (mode_r == stbu_pkg::MODE_OUTSIDE)
                      ? {{(stbu_pkg::TOTAL_W-stbu_pkg::OUTCNT_W){1'b0}}, outside_r}
                      : stbu_pkg::TOTAL_W'(1);
  assign add_sum    = add_a + add_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r  <= '0;
      comp_r <= '0;
    end else if (add_en) begin
      if (add_to_ins) ins_r <= add_sum;
      else            comp_r <= add_sum;
    end
  end

  // result fields
  always_comb begin
    status = stbu_pkg::STATUS_OK;
    case (mode_r)
      stbu_pkg::MODE_ADD:  if (!hit_r) status = stbu_pkg::STATUS_FULL;
      stbu_pkg::MODE_TAKE: if (!hit_r) status = stbu_pkg::STATUS_EMPTY;
      default:             ;
    endcase
  end

  assign taken  = (hit_r && (mode_r == stbu_pkg::MODE_TAKE)) ? mem_rd_r : '0;
  assign enough = (thresh_r == '0)
                  ? (stat.count != '0)
                  : ({{(stbu_pkg::THRESH_W-stbu_pkg::COUNT_W){1'b0}}, stat.count} >= thresh_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status;
      out_data_r[stbu_pkg::OUT_SLOT_LSB-1:stbu_pkg::OUT_TAKEN_LSB] <= taken;
      out_data_r[stbu_pkg::OUT_COUNT_LSB-1:stbu_pkg::OUT_SLOT_LSB] <=
        hit_r ? 4'(idx_r) : 4'd0;
      out_data_r[stbu_pkg::OUT_INS_LSB-1:stbu_pkg::OUT_COUNT_LSB]  <= 5'(stat.count);
      out_data_r[stbu_pkg::OUT_COMP_LSB-1:stbu_pkg::OUT_INS_LSB]   <= ins_r;
      out_data_r[stbu_pkg::OUT_ENOUGH_BIT-1:stbu_pkg::OUT_COMP_LSB] <= comp_r;
      out_data_r[stbu_pkg::OUT_ENOUGH_BIT] <= enough;
      // zero fill up to the byte boundary
      out_data_r[stbu_pkg::OUT_DATA_W-1:stbu_pkg::OUT_USED_W] <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/stbu_checker.sv =====
// port-level checker for the slot task buffer unit, bound to the top level
// depends on stbu_pkg and slot_task_buffer_unit_macros.svh
`default_nettype none

`include "slot_task_buffer_unit_macros.svh"

module stbu_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [stbu_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire [stbu_pkg::STATUS_W-1:0]    out_tuser
);

  // a stalled result holds its payload
  `STBU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one item at a time: no accept right after an accept
  `STBU_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "item accepted while busy")

  // failed add or take reports no handle and no slot
  `STBU_ASSERT(a_fail_zero, out_tvalid && out_tuser != stbu_pkg::STATUS_OK |-> out_tdata[stbu_pkg::OUT_COUNT_LSB-1:0] == '0, "failed item reports a slot")

  // occupancy never exceeds the slot count
  `STBU_ASSERT(a_count_max, out_tvalid |-> out_tdata[stbu_pkg::OUT_INS_LSB-1:stbu_pkg::OUT_COUNT_LSB] <= stbu_pkg::SLOTS, "occupancy out of range")

  // no result right after reset
  `STBU_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind slot_task_buffer_unit stbu_checker u_stbu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
